// ----- design/svbs_pkg.sv -----
// Package: constants, types and command codes for the sparse voxel block store.
`timescale 1ns / 1ps
`default_nettype none
package svbs_pkg;

  localparam int unsigned BlockEdge   = 16;
  localparam int unsigned MaxBlocks   = 16;
  localparam int unsigned CoordBits   = 16;
  localparam int unsigned EdgeBits    = $clog2(BlockEdge);
  localparam int unsigned OrgBits     = CoordBits - EdgeBits;
  localparam int unsigned VoxBits     = 3 * EdgeBits;
  localparam int unsigned EntBits     = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned MemAddrBits = EntBits + VoxBits;
  localparam int unsigned MemDepth    = MaxBlocks * (1 << VoxBits);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef logic [OrgBits-1:0] org_t;

  typedef struct packed {
    logic [1:0]         cmd;
    org_t [2:0]         org;
    logic [VoxBits-1:0] off;
    logic [31:0]        rgba;
  } op_t;

  typedef struct packed {
    logic  valid;
    op_t   op;
  } queue_t;

endpackage
`default_nettype wire

// ----- design/svbs_if.sv -----
// Interfaces: request and result channels of the sparse voxel block store.
`timescale 1ns / 1ps
`default_nettype none
interface svbs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, red_in, green_in, blue_in,
                  alpha_in, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, red_in, green_in, blue_in,
                alpha_in, output ready);
endinterface

interface svbs_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       block_found;
  logic       status;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, block_found,
                  status, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, block_found,
                status, output ready);
endinterface
`default_nettype wire

// ----- design/svbs_front.sv -----
// Front end: request decode into origin and offset, two-entry queue to the back end.
`timescale 1ns / 1ps
`default_nettype none
module svbs_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  svbs_req_if.sink            req_i,
  input  wire                 pop_i,
  output svbs_pkg::queue_t    q_o
);
  import svbs_pkg::*;

  logic [CoordBits-1:0] pos_x, pos_y, pos_z;
  op_t                  op;
  op_t                  buf_q [2];
  logic                 wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 push, pop;

  assign pos_x = CoordBits'(req_i.pos_x);
  assign pos_y = CoordBits'(req_i.pos_y);
  assign pos_z = CoordBits'(req_i.pos_z);

  always_comb begin
    op.cmd    = req_i.cmd;
    op.org[0] = pos_x[CoordBits-1:EdgeBits];
    op.org[1] = pos_y[CoordBits-1:EdgeBits];
    op.org[2] = pos_z[CoordBits-1:EdgeBits];
    op.off    = {pos_z[EdgeBits-1:0], pos_y[EdgeBits-1:0], pos_x[EdgeBits-1:0]};
    op.rgba   = {req_i.alpha_in, req_i.blue_in, req_i.green_in, req_i.red_in};
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= op;
    end
  end

  always_comb begin
    q_o.valid = (cnt_q != 2'd0);
    q_o.op    = buf_q[rd_ptr_q];
  end

endmodule
`default_nettype wire

// ----- design/svbs_back.sv -----
// Back end: block table lookup, allocation with clearing sweep, voxel memory, result register.
`timescale 1ns / 1ps
`default_nettype none
module svbs_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  svbs_pkg::queue_t    q_i,
  output logic                pop_o,
  svbs_res_if.source          res_o
);
  import svbs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_RDAT = 5'b00100,
    S_CLR  = 5'b01000,
    S_WR   = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  op_t                    item_q;
  logic [MaxBlocks-1:0]   valid_q, valid_d;
  org_t [2:0]             origin_q [MaxBlocks];
  logic [MaxBlocks-1:0]   match;
  logic                   hit, full;
  logic [EntBits-1:0]     hit_idx, free_idx;
  logic [EntBits-1:0]     ent_q, ent_d;
  logic [VoxBits-1:0]     clr_cnt_q, clr_cnt_d;
  logic                   can_emit;

  logic [31:0]            mem_q [MemDepth];
  logic [31:0]            rdata_q;
  logic                   mem_we, mem_re;
  logic [MemAddrBits-1:0] mem_addr;
  logic [31:0]            mem_wdata;

  logic                   res_valid_q, res_valid_d;
  logic [31:0]            res_rgba_q, res_rgba_d;
  logic                   res_found_q, res_found_d;
  logic                   res_status_q, res_status_d;
  logic                   alloc;

  always_comb begin
    for (int i = 0; i < MaxBlocks; i++) begin
      match[i] = valid_q[i] && (origin_q[i] == item_q.org);
    end
    hit      = |match;
    full     = &valid_q;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = EntBits'(i);
      if (!valid_q[i]) free_idx = EntBits'(i);
    end
  end

  assign can_emit = !res_valid_q || res_o.ready;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    ent_d        = ent_q;
    clr_cnt_d    = clr_cnt_q;
    pop_o        = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = {hit_idx, item_q.off};
    mem_wdata    = item_q.rgba;
    alloc        = 1'b0;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_rgba_d   = res_rgba_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o   = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (can_emit) begin
          res_rgba_d   = '0;
          res_found_d  = 1'b0;
          res_status_d = 1'b0;
          state_d      = S_IDLE;
          case (item_q.cmd)
            CMD_READ: begin
              res_found_d = hit;
              if (hit) begin
                mem_re  = 1'b1;
                state_d = S_RDAT;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            CMD_WRITE: begin
              res_found_d = hit;
              if (hit) begin
                mem_we      = 1'b1;
                res_valid_d = 1'b1;
              end else if (full) begin
                res_status_d = 1'b1;
                res_valid_d  = 1'b1;
              end else begin
                alloc            = 1'b1;
                valid_d[free_idx] = 1'b1;
                ent_d            = free_idx;
                clr_cnt_d        = '0;
                state_d          = S_CLR;
              end
            end
            CMD_CLEAR: begin
              res_found_d = hit;
              res_valid_d = 1'b1;
              if (hit) valid_d[hit_idx] = 1'b0;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_RDAT: begin
        res_rgba_d  = rdata_q;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = {ent_q, clr_cnt_q};
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) state_d = S_WR;
      end
      S_WR: begin
        if (can_emit) begin
          mem_we      = 1'b1;
          mem_addr    = {ent_q, item_q.off};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q        <= ent_d;
    clr_cnt_q    <= clr_cnt_d;
    res_rgba_q   <= res_rgba_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    if (pop_o) item_q <= q_i.op;
    if (alloc) origin_q[free_idx] <= item_q.org;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.red_out     = res_rgba_q[7:0];
  assign res_o.green_out   = res_rgba_q[15:8];
  assign res_o.blue_out    = res_rgba_q[23:16];
  assign res_o.alpha_out   = res_rgba_q[31:24];
  assign res_o.block_found = res_found_q;
  assign res_o.status      = res_status_q;

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |-> $onehot0(match))
    else $error("duplicate block origin in table");

  a_clr_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> valid_q[ent_q])
    else $error("clearing sweep on a free entry");

  a_wr_after_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q == S_CLR || state_q == S_WR))
    else $error("allocating write without clearing sweep");

  a_no_drop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |=> res_valid_q)
    else $error("pending result lost");

endmodule
`default_nettype wire

// ----- design/sparse_voxel_block_store.sv -----
// Top level: sparse RGBA voxel store held in 16^3 blocks behind a 16-entry block table.
// Usage:
//   req_i carries a request: cmd (0 read, 1 write, 2 clear block), signed pos_x/y/z and
//   the RGBA to write. res_o returns exactly one result per request, in order: the voxel
//   read (zero otherwise), block_found and status (1 when a write finds the table full).
//   A two-entry queue parts the decoding front end from the back end, so requests are
//   taken while the back end works or a result waits.
//   In the back end, one request at a time: a read hit waits on the registered voxel
//   memory read; a write that allocates a block first runs the clearing sweep, writing
//   zero to each of the block's 4096 voxels through the single memory port.
//   Reset frees all table entries; no memory pass is needed at reset since a block's
//   voxels are zeroed when it is allocated.
//   When res_o stalls, one result waits in the output register, the back end holds its
//   next request and the queue fills, after which req_i.ready falls.
`timescale 1ns / 1ps
`default_nettype none
module sparse_voxel_block_store (
  input  wire         clk_i,
  input  wire         rst_ni,
  svbs_req_if.sink    req_i,
  svbs_res_if.source  res_o
);
  import svbs_pkg::*;

  queue_t q;
  logic   pop;

  svbs_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .pop_i  (pop),
    .q_o    (q)
  );

  svbs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule
`default_nettype wire
